// File: rtl/tre_pkg.sv
// ----------------------------------------------------------------------------
// tre_pkg
// Shared types and constants for the TGA run-length pixel encoder: the
// command that travels from the front part to the back part, the raw buffer
// write port and the back part's read status.
// ----------------------------------------------------------------------------
package tre_pkg;

    // Field widths fixed by the pixel format and the packet header layout.
    localparam int PIX_W = 24;
    localparam int CNT_W = 6;   // raw pixel count, holds up to 63
    localparam int RUN_W = 8;   // run length, holds up to 255
    localparam int HDR_W = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_RAW_LIMIT = 32;
    localparam int DEF_RUN_LIMIT = 128;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 4;

    // Kinds of packet command.
    typedef enum logic {
        CMD_RUN,
        CMD_RAW
    } cmd_kind_t;

    // One packet command. A run carries its finished header and pixel; a raw
    // packet carries its pixel count and the raw buffer bank that holds it.
    typedef struct packed {
        cmd_kind_t              kind;
        logic                   last;
        logic                   bank;
        logic [CNT_W-1:0]       count;
        logic [HDR_W-1:0]       header;
        logic [PIX_W-1:0]       pixel;
    } cmd_t;

    // Write port into the raw pixel buffer.
    typedef struct packed {
        logic                   en;
        logic                   bank;
        logic [CNT_W-1:0]       addr;
        logic [PIX_W-1:0]       data;
    } wr_t;

    // Read status from the back part: a raw buffer read this cycle, its bank,
    // and whether it is the final read of that packet.
    typedef struct packed {
        logic                   rd_en;
        logic                   rd_bank;
        logic                   rd_final;
    } back_stat_t;

endpackage

// File: rtl/tga_rle_pixel_encoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_encoder
// Run-length encoder that turns a raster stream of 24-bit pixels into the
// packet stream of a TGA type-10 image, one result per emitted pixel.
//
// Input channel: in_valid / in_stall with red, green, blue, end_of_line.
// Output channel: out_valid / out_stall; each transaction carries one pixel,
// the packet header on the first result of a packet, and last on the final
// result caused by an input pixel.
// Throughput: a pixel without end_of_line is taken every cycle while the
// back keeps up; a pixel with end_of_line holds the input while the line is
// flushed. The output sends one result per cycle while out_stall is low, so
// a raw packet occupies the back for one result per stored pixel; the
// four-entry command queue and the two raw buffer banks absorb these bursts.
// Path: a packet command passes the queue entry, the read stage and the
// output register in that order before its first result is on the output.
// Reset: nothing is held, the queue is empty, no result is pending; the raw
// buffer needs no clearing. When out_stall is high the output holds and the
// pipeline backs up into in_stall.
// ----------------------------------------------------------------------------
module tga_rle_pixel_encoder #(
    parameter int RAW_LIMIT = tre_pkg::DEF_RAW_LIMIT,
    parameter int RUN_LIMIT = tre_pkg::DEF_RUN_LIMIT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        end_of_line,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        header_valid,
    output logic [7:0]  packet_header,
    output logic        pixel_valid,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_green,
    output logic [7:0]  out_red,
    output logic        last
);
    import tre_pkg::*;

    logic [PIX_W-1:0]   in_pixel;
    logic [PIX_W-1:0]   out_pixel;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    cmd_t               q_cmd;
    cmd_t               q_head;
    wr_t                mem_wr;
    back_stat_t         back_stat;

    assign in_pixel  = {red, green, blue};
    assign out_blue  = out_pixel[7:0];
    assign out_green = out_pixel[15:8];
    assign out_red   = out_pixel[23:16];

    // Front: pixel classification and raw buffer writes.
    tre_front #(
        .RAW_LIMIT (RAW_LIMIT),
        .RUN_LIMIT (RUN_LIMIT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_pixel  (in_pixel),
        .in_eol    (end_of_line),
        .q_push    (q_push),
        .q_cmd     (q_cmd),
        .q_full    (q_full),
        .mem_wr    (mem_wr),
        .back_stat (back_stat)
    );

    // Command queue between front and back.
    tre_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // Back: packet output.
    tre_back #(
        .RAW_LIMIT (RAW_LIMIT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .mem_wr        (mem_wr),
        .back_stat     (back_stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .header_valid  (header_valid),
        .packet_header (packet_header),
        .pixel_valid   (pixel_valid),
        .out_pixel     (out_pixel),
        .last          (last)
    );

    // The front never pushes a command into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // The front never writes the bank the back is draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr.en && back_stat.rd_en) |-> (mem_wr.bank != back_stat.rd_bank))
        else $error("raw buffer bank written while being read");

    // A raw packet header never counts more pixels than the buffer holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && header_valid && !packet_header[7])
            |-> (packet_header[6:0] < 7'(RAW_LIMIT)))
        else $error("raw packet header exceeds the raw limit");

endmodule

// File: rtl/tre_front.sv
// ----------------------------------------------------------------------------
// tre_front
// Accepts pixels, tracks the held pixel, the run length and the raw pixel
// count, writes raw pixels into the double-banked raw buffer and pushes at most
// one packet command per cycle into the command queue.
// ----------------------------------------------------------------------------
module tre_front #(
    parameter int RAW_LIMIT = tre_pkg::DEF_RAW_LIMIT,
    parameter int RUN_LIMIT = tre_pkg::DEF_RUN_LIMIT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [tre_pkg::PIX_W-1:0] in_pixel,
    input  logic                     in_eol,
    output logic                     q_push,
    output tre_pkg::cmd_t            q_cmd,
    input  logic                     q_full,
    output tre_pkg::wr_t             mem_wr,
    input  tre_pkg::back_stat_t      back_stat
);
    import tre_pkg::*;

    typedef enum logic [1:0] {
        PH_STEP,
        PH_TAIL,
        PH_FLUSH
    } phase_t;

    localparam logic [CNT_W-1:0] RAW_FULL_M1 = CNT_W'(RAW_LIMIT - 1);
    localparam logic [CNT_W-1:0] RAW_FULL    = CNT_W'(RAW_LIMIT);
    localparam logic [RUN_W-1:0] RUN_MAX     = RUN_W'(RUN_LIMIT);

    phase_t             phase_reg, phase_next;
    logic [PIX_W-1:0]   held_pixel_reg, held_pixel_next;
    logic               held_valid_reg, held_valid_next;
    logic [RUN_W-1:0]   run_len_reg, run_len_next;
    logic [CNT_W-1:0]   raw_count_reg, raw_count_next;
    logic               wr_bank_reg, wr_bank_next;
    logic [1:0]         pending_reg, pending_next;

    logic               can_act;
    logic               accept;
    logic [RUN_W-1:0]   run_m1;
    logic [HDR_W-1:0]   run_hdr;

    assign run_m1  = run_len_reg - RUN_W'(1);
    assign run_hdr = {1'b1, run_m1[HDR_W-2:0]};

    // The front acts only with queue room and a write bank the back has freed.
    assign can_act  = !q_full && !pending_reg[wr_bank_reg];
    assign in_stall = (phase_reg != PH_STEP) || !can_act;
    assign accept   = in_valid && !in_stall;

    // Classification of each pixel and of the line-end flush.
    always_comb
    begin
        phase_next      = phase_reg;
        held_pixel_next = held_pixel_reg;
        held_valid_next = held_valid_reg;
        run_len_next    = run_len_reg;
        raw_count_next  = raw_count_reg;
        wr_bank_next    = wr_bank_reg;
        pending_next    = pending_reg;
        q_push          = 1'b0;
        q_cmd           = '0;
        mem_wr          = '0;

        // The back frees a bank once its final raw pixel is read.
        if (back_stat.rd_en && back_stat.rd_final)
        begin
            pending_next[back_stat.rd_bank] = 1'b0;
        end

        case (phase_reg)
            PH_STEP:
            begin
                if (accept)
                begin
                    if (!held_valid_reg)
                    begin
                        held_pixel_next = in_pixel;
                        held_valid_next = 1'b1;
                        run_len_next    = RUN_W'(1);
                    end
                    else if (in_pixel == held_pixel_reg && run_len_reg < RUN_MAX)
                    begin
                        // A run of two begins: pending raw pixels go out first.
                        if (run_len_reg == RUN_W'(1) && raw_count_reg != '0)
                        begin
                            q_push                     = 1'b1;
                            q_cmd.kind                 = CMD_RAW;
                            q_cmd.last                 = !in_eol;
                            q_cmd.bank                 = wr_bank_reg;
                            q_cmd.count                = raw_count_reg;
                            pending_next[wr_bank_reg]  = 1'b1;
                            wr_bank_next               = !wr_bank_reg;
                            raw_count_next             = '0;
                        end
                        run_len_next = run_len_reg + RUN_W'(1);
                    end
                    else
                    begin
                        if (run_len_reg >= RUN_W'(2))
                        begin
                            q_push       = 1'b1;
                            q_cmd.kind   = CMD_RUN;
                            q_cmd.last   = !in_eol;
                            q_cmd.header = run_hdr;
                            q_cmd.pixel  = held_pixel_reg;
                        end
                        else
                        begin
                            mem_wr.en   = 1'b1;
                            mem_wr.bank = wr_bank_reg;
                            mem_wr.addr = raw_count_reg;
                            mem_wr.data = held_pixel_reg;
                            if (raw_count_reg == RAW_FULL_M1)
                            begin
                                q_push                    = 1'b1;
                                q_cmd.kind                = CMD_RAW;
                                q_cmd.last                = !in_eol;
                                q_cmd.bank                = wr_bank_reg;
                                q_cmd.count               = RAW_FULL;
                                pending_next[wr_bank_reg] = 1'b1;
                                wr_bank_next              = !wr_bank_reg;
                                raw_count_next            = '0;
                            end
                            else
                            begin
                                raw_count_next = raw_count_reg + CNT_W'(1);
                            end
                        end
                        held_pixel_next = in_pixel;
                        run_len_next    = RUN_W'(1);
                    end
                    if (in_eol)
                    begin
                        phase_next = PH_TAIL;
                    end
                end
            end

            PH_TAIL:
            begin
                // Line end: flush the held run or single pixel.
                if (can_act)
                begin
                    if (run_len_reg >= RUN_W'(2))
                    begin
                        q_push       = 1'b1;
                        q_cmd.kind   = CMD_RUN;
                        q_cmd.last   = (raw_count_reg == '0);
                        q_cmd.header = run_hdr;
                        q_cmd.pixel  = held_pixel_reg;
                        phase_next   = (raw_count_reg == '0) ? PH_STEP : PH_FLUSH;
                    end
                    else
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.bank = wr_bank_reg;
                        mem_wr.addr = raw_count_reg;
                        mem_wr.data = held_pixel_reg;
                        if (raw_count_reg == RAW_FULL_M1)
                        begin
                            q_push                    = 1'b1;
                            q_cmd.kind                = CMD_RAW;
                            q_cmd.last                = 1'b1;
                            q_cmd.bank                = wr_bank_reg;
                            q_cmd.count               = RAW_FULL;
                            pending_next[wr_bank_reg] = 1'b1;
                            wr_bank_next              = !wr_bank_reg;
                            raw_count_next            = '0;
                            phase_next                = PH_STEP;
                        end
                        else
                        begin
                            raw_count_next = raw_count_reg + CNT_W'(1);
                            phase_next     = PH_FLUSH;
                        end
                    end
                    held_valid_next = 1'b0;
                    held_pixel_next = '0;
                    run_len_next    = '0;
                end
            end

            PH_FLUSH:
            begin
                // Line end: the remaining raw pixels form the last packet.
                if (can_act)
                begin
                    q_push                    = 1'b1;
                    q_cmd.kind                = CMD_RAW;
                    q_cmd.last                = 1'b1;
                    q_cmd.bank                = wr_bank_reg;
                    q_cmd.count               = raw_count_reg;
                    pending_next[wr_bank_reg] = 1'b1;
                    wr_bank_next              = !wr_bank_reg;
                    raw_count_next            = '0;
                    phase_next                = PH_STEP;
                end
            end

            default:
            begin
                phase_next = PH_STEP;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_STEP;
            held_pixel_reg <= '0;
            held_valid_reg <= 1'b0;
            run_len_reg    <= '0;
            raw_count_reg  <= '0;
            wr_bank_reg    <= 1'b0;
            pending_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_pixel_reg <= held_pixel_next;
            held_valid_reg <= held_valid_next;
            run_len_reg    <= run_len_next;
            raw_count_reg  <= raw_count_next;
            wr_bank_reg    <= wr_bank_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

// File: rtl/tre_queue.sv
// ----------------------------------------------------------------------------
// tre_queue
// Small first-in first-out queue of packet commands between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module tre_queue #(
    parameter int DEPTH = tre_pkg::Q_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tre_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output tre_pkg::cmd_t head,
    output logic          empty
);
    import tre_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    cmd_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  fill_reg, fill_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (fill_reg == FULL_CNT);
    assign empty   = (fill_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + CNT_QW'(1);
            2'b01:   fill_next = fill_reg - CNT_QW'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/tre_back.sv
// ----------------------------------------------------------------------------
// tre_back
// Carries out packet commands: a run gives one result, a raw packet gives one
// result per stored pixel read from the raw buffer. A read stage and an
// output register form a two-stage pipeline that holds under output stall.
// ----------------------------------------------------------------------------
module tre_back #(
    parameter int RAW_LIMIT = tre_pkg::DEF_RAW_LIMIT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tre_pkg::cmd_t              q_head,
    input  logic                       q_empty,
    output logic                       q_pop,
    input  tre_pkg::wr_t               mem_wr,
    output tre_pkg::back_stat_t        back_stat,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       header_valid,
    output logic [tre_pkg::HDR_W-1:0]  packet_header,
    output logic                       pixel_valid,
    output logic [tre_pkg::PIX_W-1:0]  out_pixel,
    output logic                       last
);
    import tre_pkg::*;

    localparam int IDX_W = (RAW_LIMIT > 1) ? $clog2(RAW_LIMIT) : 1;

    // Raw pixel buffer, two banks so the front fills one while one drains.
    logic [PIX_W-1:0]   raw_mem [2][RAW_LIMIT];
    logic [PIX_W-1:0]   mem_q_reg;

    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               r_valid_reg, r_valid_next;
    logic               o_valid_reg, o_valid_next;

    logic               r_hv_reg;
    logic [HDR_W-1:0]   r_hdr_reg;
    logic               r_last_reg;
    logic               r_from_mem_reg;
    logic [PIX_W-1:0]   r_pix_reg;

    logic               o_hv_reg;
    logic [HDR_W-1:0]   o_hdr_reg;
    logic               o_last_reg;
    logic [PIX_W-1:0]   o_pix_reg;

    logic               o_free;
    logic               r_go;
    logic               r_open;
    logic               issue;
    logic               is_raw;
    logic               final_one;
    logic [CNT_W-1:0]   cnt_m1;
    logic [HDR_W-1:0]   raw_hdr;
    logic               first_one;

    assign o_free    = !o_valid_reg || !out_stall;
    assign r_go      = r_valid_reg && o_free;
    assign r_open    = !r_valid_reg || o_free;
    assign issue     = r_open && !q_empty;
    assign is_raw    = (q_head.kind == CMD_RAW);
    assign cnt_m1    = q_head.count - CNT_W'(1);
    assign raw_hdr   = {1'b0, (HDR_W - 1)'(cnt_m1)};
    assign first_one = (idx_reg == '0);
    assign final_one = !is_raw || (idx_reg == cnt_m1);
    assign q_pop     = issue && final_one;

    assign back_stat.rd_en    = issue && is_raw;
    assign back_stat.rd_bank  = q_head.bank;
    assign back_stat.rd_final = final_one;

    // Step through the pixels of a raw packet.
    always_comb
    begin
        idx_next     = idx_reg;
        r_valid_next = r_valid_reg;
        o_valid_next = o_valid_reg;
        if (issue && is_raw)
        begin
            idx_next = final_one ? '0 : idx_reg + CNT_W'(1);
        end
        if (issue)
        begin
            r_valid_next = 1'b1;
        end
        else if (r_go)
        begin
            r_valid_next = 1'b0;
        end
        if (r_go)
        begin
            o_valid_next = 1'b1;
        end
        else if (o_free)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            r_valid_reg <= r_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Raw buffer write from the front and registered read for the back.
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            raw_mem[mem_wr.bank][mem_wr.addr[IDX_W-1:0]] <= mem_wr.data;
        end
        if (issue && is_raw)
        begin
            mem_q_reg <= raw_mem[q_head.bank][idx_reg[IDX_W-1:0]];
        end
    end

    // Read stage and output register payload.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            r_hv_reg       <= !is_raw || first_one;
            r_hdr_reg      <= !is_raw ? q_head.header : (first_one ? raw_hdr : '0);
            r_last_reg     <= q_head.last && final_one;
            r_from_mem_reg <= is_raw;
            r_pix_reg      <= q_head.pixel;
        end
        if (r_go)
        begin
            o_hv_reg   <= r_hv_reg;
            o_hdr_reg  <= r_hdr_reg;
            o_last_reg <= r_last_reg;
            o_pix_reg  <= r_from_mem_reg ? mem_q_reg : r_pix_reg;
        end
    end

    assign out_valid     = o_valid_reg;
    assign header_valid  = o_hv_reg;
    assign packet_header = o_hdr_reg;
    assign pixel_valid   = 1'b1;
    assign out_pixel     = o_pix_reg;
    assign last          = o_last_reg;

endmodule

// File: dv/tga_rle_pixel_encoder_tb.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_encoder_tb
// Self-checking testbench for the TGA run-length pixel encoder. Pixel lines
// are driven into the block, a scoreboard predicts the run and raw packets
// that each accepted pixel releases, and every output transaction is checked
// in order. The run covers short directed lines, one line that reaches both
// packet size limits, and random lines of runs and raw stretches with noise.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tga_rle_pixel_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tre_pkg::*;

    localparam int RAW_MAX       = DEF_RAW_LIMIT;
    localparam int RUN_MAX       = DEF_RUN_LIMIT;
    localparam logic [7:0] RUN_FLAG = 8'h80;
    localparam int ITEMS         = 370;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;

    // One output transaction as the encoder should produce it.
    typedef struct {
        logic       hdr_ok;
        logic [7:0] hdr;
        logic       pix_ok;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic       fin;
    } rle_result_t;

    // Scoreboard: encodes accepted pixels into expected packet transactions
    // and checks the block's transactions against them in order.
    class pixel_rle_scoreboard;
        rle_result_t packet_q[$];
        logic [23:0] held_px;
        logic        held_ok;
        int          run_len;
        logic [23:0] raw_buf[RAW_MAX];
        int          raw_cnt;
        int          errors;
        int          n_pixels;
        int          n_lines;
        int          n_results;
        int          n_runs;
        int          n_raws;
        int          n_run_cap;
        int          n_raw_cap;
        int          max_burst;

        function new();
            held_px   = '0;
            held_ok   = 1'b0;
            run_len   = 0;
            raw_cnt   = 0;
            errors    = 0;
            n_pixels  = 0;
            n_lines   = 0;
            n_results = 0;
            n_runs    = 0;
            n_raws    = 0;
            n_run_cap = 0;
            n_raw_cap = 0;
            max_burst = 0;
        endfunction

        function int pending();
            return packet_q.size();
        endfunction

        function void push_pixel(logic hv, logic [7:0] hdr, logic [23:0] px);
            rle_result_t res;
            res.hdr_ok = hv;
            res.hdr    = hv ? hdr : 8'h00;
            res.pix_ok = 1'b1;
            res.r      = px[23:16];
            res.g      = px[15:8];
            res.b      = px[7:0];
            res.fin    = 1'b0;
            packet_q.push_back(res);
        endfunction

        // A raw packet: header with the first pixel, then the rest.
        function void flush_raw();
            for (int i = 0; i < raw_cnt; i++)
                push_pixel(i == 0, 8'((raw_cnt - 1) & 8'h7F), raw_buf[i]);
            raw_cnt = 0;
            n_raws++;
        endfunction

        function void add_raw(logic [23:0] px);
            if (raw_cnt < RAW_MAX) begin
                raw_buf[raw_cnt] = px;
                raw_cnt++;
            end
            if (raw_cnt >= RAW_MAX) begin
                n_raw_cap++;
                flush_raw();
            end
        endfunction

        // The held pixel leaves either as a run packet or into the raw buffer.
        function void close_held();
            if (run_len >= 2) begin
                push_pixel(1'b1, RUN_FLAG | 8'((run_len - 1) & 8'h7F), held_px);
                n_runs++;
            end
            else
                add_raw(held_px);
        endfunction

        function void note_pixel(logic [23:0] px, logic eol);
            int          start;
            rle_result_t tail;
            start = packet_q.size();
            n_pixels++;
            if (held_ok) begin
                if (px == held_px && run_len < RUN_MAX) begin
                    // A run of two pushes out whatever raw pixels wait ahead of it.
                    if (run_len == 1 && raw_cnt > 0)
                        flush_raw();
                    run_len++;
                end
                else begin
                    if (px == held_px)
                        n_run_cap++;
                    close_held();
                    held_px = px;
                    run_len = 1;
                end
            end
            else begin
                held_px = px;
                run_len = 1;
                held_ok = 1'b1;
            end
            // Nothing crosses a line end.
            if (eol) begin
                close_held();
                if (raw_cnt > 0)
                    flush_raw();
                held_ok = 1'b0;
                held_px = '0;
                run_len = 0;
                n_lines++;
            end
            if (packet_q.size() > start) begin
                tail = packet_q.pop_back();
                tail.fin = 1'b1;
                packet_q.push_back(tail);
                if (packet_q.size() - start > max_burst)
                    max_burst = packet_q.size() - start;
            end
        endfunction

        function void cmp_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: mismatch on %s, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(rle_result_t got);
            rle_result_t want;
            if (packet_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual hdr %0h pix %0h",
                         $time, got.hdr, {got.r, got.g, got.b});
                return;
            end
            want = packet_q.pop_front();
            n_results++;
            cmp_field("header_valid", want.hdr_ok, got.hdr_ok);
            cmp_field("packet_header", want.hdr, got.hdr);
            cmp_field("pixel_valid", want.pix_ok, got.pix_ok);
            cmp_field("out_blue", want.b, got.b);
            cmp_field("out_green", want.g, got.g);
            cmp_field("out_red", want.r, got.r);
            cmp_field("last", want.fin, got.fin);
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [7:0] red           = 8'h00;
    logic [7:0] green         = 8'h00;
    logic [7:0] blue          = 8'h00;
    logic       end_of_line   = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic       header_valid;
    logic [7:0] packet_header;
    logic       pixel_valid;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       last;

    pixel_rle_scoreboard sb = new();
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  sent           = 0;
    int  in_stall_cycles = 0;
    int  cycle_count    = 0;
    bit  hold_req       = 1'b0;
    logic [23:0] palette[4] = '{24'h000000, 24'hFFFFFF, 24'h3C5AA5, 24'hC3A55A};

    tga_rle_pixel_encoder #(
        .RAW_LIMIT      (RAW_MAX),
        .RUN_LIMIT      (RUN_MAX)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .end_of_line    (end_of_line),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .header_valid   (header_valid),
        .packet_header  (packet_header),
        .pixel_valid    (pixel_valid),
        .out_blue       (out_blue),
        .out_green      (out_green),
        .out_red        (out_red),
        .last           (last)
    );

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit in cycles; a hang ends here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d transactions outstanding.",
                 cycle_count, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_count;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                hold_count = 0;
                while (hold_count < LONG_HOLD)
                begin
                    @(posedge clk);
                    hold_count++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check each accepted output transaction.
    always @(posedge clk)
    begin
        rle_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.hdr_ok = header_valid;
            got.hdr    = packet_header;
            got.pix_ok = pixel_valid;
            got.b      = out_blue;
            got.g      = out_green;
            got.r      = out_red;
            got.fin    = last;
            sb.check_result(got);
        end
    end

    // Offer one pixel and wait until the block takes it.
    task automatic send_pixel(input logic [23:0] px, input logic eol);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        red         <= px[23:16];
        green       <= px[15:8];
        blue        <= px[7:0];
        end_of_line <= eol;
        @(posedge clk);
        while (in_stall)
        begin
            in_stall_cycles++;
            @(posedge clk);
        end
        sb.note_pixel(px, eol);
        sent++;
    endtask

    // Stop offering pixels until every expected transaction has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // A color that differs from its left neighbor.
    function automatic logic [23:0] pick_color(logic [23:0] prev, bit use_pal);
        logic [23:0] c;
        int          idx;
        if (use_pal)
        begin
            idx = $urandom_range(3);
            c = palette[idx];
            if (c == prev)
                c = palette[(idx + 1) % 4];
        end
        else
        begin
            c = 24'($urandom);
            if (c == prev)
                c = ~c;
        end
        return c;
    endfunction

    // One image line built from runs and raw stretches. The limit line has a
    // raw stretch past the raw limit followed by a run past the run limit.
    task automatic send_line(input bit limit_line);
        int          n_seg;
        int          len;
        bit          is_run;
        bit          use_pal;
        bit          broken;
        logic [23:0] px;
        logic [23:0] prev;
        n_seg   = limit_line ? 2 : $urandom_range(1, 4);
        use_pal = !limit_line && ($urandom_range(3) == 0);
        broken  = !limit_line && ($urandom_range(9) == 0);
        prev    = 24'($urandom);
        for (int s = 0; s < n_seg; s++)
        begin
            is_run = limit_line ? (s == 1) : $urandom_range(1);
            if (limit_line)
                len = is_run ? 130 : 34;
            else if (is_run)
                len = ($urandom_range(24) == 0) ? $urandom_range(127, 131)
                                                : $urandom_range(2, 6);
            else
                len = ($urandom_range(15) == 0) ? $urandom_range(31, 34)
                                                : $urandom_range(1, 5);
            px = pick_color(prev, use_pal);
            for (int k = 0; k < len; k++)
            begin
                if (!is_run && k > 0)
                    px = pick_color(prev, use_pal);
                send_pixel(px, (s == n_seg - 1) && (k == len - 1) && !broken);
                prev = px;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        int n_noise;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First phase: sender idles lightly, receiver stalls heavily.
        send_idle_pct  = 34;
        recv_stall_pct = 79;

        // Directed lines: single pixels at the extremes, a run of two,
        // raw pixels flushed by a starting run, and a run followed by raw.
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'hFF00FF, 1'b0);
        send_pixel(24'hFF00FF, 1'b1);
        send_pixel(24'h010203, 1'b0);
        send_pixel(24'hAA55AA, 1'b0);
        send_pixel(24'h55AA55, 1'b0);
        send_pixel(24'h55AA55, 1'b0);
        send_pixel(24'h55AA55, 1'b1);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'hFFFF00, 1'b0);
        send_pixel(24'h0000FF, 1'b1);
        send_pixel(24'h800080, 1'b0);
        send_pixel(24'h7F7F7F, 1'b1);

        // The receiver holds off while the limit line keeps coming.
        hold_req = 1'b1;
        send_line(1'b1);

        while (sent < ITEMS)
        begin
            if (send_idle_pct == 34 && sent >= 200)
            begin
                wait_drained();
                send_idle_pct  = 79;
                recv_stall_pct = 34;
            end
            else if (send_idle_pct == 79 && sent >= 285)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // Occasional loose pixels with arbitrary line ends.
            if ($urandom_range(5) == 0)
            begin
                n_noise = $urandom_range(1, 4);
                repeat (n_noise) send_pixel(24'($urandom), 1'($urandom_range(1)));
            end
            send_line(1'b0);
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels in %0d lines; checked %0d transactions in %0d run and %0d raw packets.",
                 sb.n_pixels, sb.n_lines, sb.n_results, sb.n_runs, sb.n_raws);
        $display("Run limit reached %0d times, raw limit %0d times, largest burst %0d, input stalled %0d cycles.",
                 sb.n_run_cap, sb.n_raw_cap, sb.max_burst, in_stall_cycles);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
